@@ rtl/core/slc_pkg.sv @@
// Package for the skyline Cholesky block: opcodes, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slc_pkg;
  localparam int VW = 48;
  localparam logic signed [VW-1:0] VMAX = 48'sh7FFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_WR_DIAG = 3'd0,
    OP_WR_PTR  = 3'd1,
    OP_WR_PROF = 3'd2,
    OP_FACTOR  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOTDEF = 2'd1,
    ST_RANGE  = 2'd2
  } stat_t;

  localparam logic [0:0] REG_MATRIX_SIZE = 1'd0;

  typedef enum logic [4:0] {
    S_IDLE, S_ROW, S_ROW_W1, S_ROW_W2, S_ROW_CHK,
    S_COL, S_COLP_W1, S_COLP_W2, S_COL_SET,
    S_DOT_RD, S_DOT_W, S_DOT_MUL, S_DOT_ACC,
    S_DIV_RD, S_DIV_W, S_DIV_RUN, S_DIV_WR,
    S_SQ_RD, S_SQ_W, S_SQ_MUL, S_SQ_ACC,
    S_PIV_RD, S_PIV_W, S_SQRT_RUN, S_SQRT_WR,
    S_RD_W, S_DONE
  } seq_state_t;

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b,
                                                  input logic sub);
    logic signed [VW+1:0] s;
    begin
      s = sub ? ($signed({{2{a[VW-1]}}, a}) - $signed({{2{b[VW-1]}}, b}))
              : ($signed({{2{a[VW-1]}}, a}) + $signed({{2{b[VW-1]}}, b}));
      if (s > $signed({2'b00, VMAX})) sat_add = VMAX;
      else if (s < -$signed({2'b00, VMAX})) sat_add = -VMAX;
      else sat_add = s[VW-1:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/skyline_cholesky_factor.sv @@
// Top level of the skyline Cholesky block: stores, APB register, sequencer.
// Depends on slc_pkg, slc_ram, slc_mul and slc_divsqrt.
//
//  channel  | direction | payload
//  in_      | slave     | tdata: opcode[2:0], index[12:3], value[60:13]
//  out_     | master     | tdata: read_value[47:0], status[49:48]
//  cfg_     | APB       | matrix_size at address 0
//
// Write and unused items finish in S_DONE, and reads finish in S_RD_W after it.
// A factorize item walks the profile row by row; each dot-product term goes through
// the one profile RAM port and the multiplier, each divide with its reads and
// write-back through slc_divsqrt, and each square root through the same unit.
// Reset clears control state only; the stores are undefined until written.
// A result waits in the output register; the next item is taken once it has left.
`timescale 1ns / 1ps
`default_nettype none
module skyline_cholesky_factor
  import slc_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_PROFILE = 1024,
  parameter int FRAC_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // opcode, index, value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // read_value, status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int PRW = $clog2(MAX_ROWS + 1);
  localparam int PW = $clog2(MAX_PROFILE);
  localparam int PTW = $clog2(MAX_PROFILE + 1);
  localparam int CW = PTW + 1;

  logic [6:0] msize_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, msize_r};
  always_ff @(posedge clk) begin
    if (!rst_n) msize_r <= 7'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_MATRIX_SIZE)
      msize_r <= cfg_pwdata[6:0];
  end

  logic [2:0] op_r;
  logic [9:0] idx_r;
  logic signed [VW-1:0] val_r;
  seq_state_t st_r, st_nxt;
  logic flag_r, flag_nxt;
  logic ov_r;
  logic signed [VW-1:0] orv_r;
  stat_t ost_r;
  logic res_set;
  logic signed [VW-1:0] res_v;
  stat_t res_s;

  logic d_we, r_we, p_we;
  logic [RW-1:0] d_a;
  logic [PRW-1:0] r_a;
  logic [PW-1:0] p_a;
  logic signed [VW-1:0] d_wd, d_rd, p_wd, p_rd;
  logic [PTW-1:0] r_wd, r_rd;

  slc_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_diag (
    .clk(clk), .we(d_we), .addr(d_a), .wdata(d_wd), .rdata(d_rd));
  slc_ram #(.WIDTH(PTW), .DEPTH(MAX_ROWS + 1)) u_ptr (
    .clk(clk), .we(r_we), .addr(r_a), .wdata(r_wd), .rdata(r_rd));
  slc_ram #(.WIDTH(VW), .DEPTH(MAX_PROFILE)) u_prof (
    .clk(clk), .we(p_we), .addr(p_a), .wdata(p_wd), .rdata(p_rd));

  // Factorization registers.
  logic [RW:0] n_r, i_r, j_r;
  logic [CW-1:0] i0_r, i1_r, k_r, ei_r, ej_r, begi_r, ej0_r;
  logic signed [VW-1:0] acc_r, opa_r;
  logic [RW:0] i_nxt, j_nxt;
  logic [CW-1:0] i0_nxt, i1_nxt, k_nxt, ei_nxt, ej_nxt, begi_nxt, ej0_nxt;
  logic signed [VW-1:0] acc_nxt, opa_nxt;
  logic [CW-1:0] ej1_r, ej1_nxt, begj;

  logic m_start, m_done;
  logic signed [VW-1:0] m_p;
  logic q_start, q_sqrt, q_done;
  logic signed [VW-1:0] q_num, q_den, q_res;
  slc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(opa_r), .b(p_rd),
    .done(m_done), .p(m_p));
  slc_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (
    .clk(clk), .rst_n(rst_n), .start(q_start), .is_sqrt(q_sqrt), .num(q_num),
    .den(q_den), .done(q_done), .res(q_res));

  logic in_acc;
  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, ost_r, orv_r};

  always_comb begin
    st_nxt = st_r;
    flag_nxt = flag_r;
    res_set = 1'b0;
    res_v = '0;
    res_s = ST_OK;
    d_we = 1'b0; r_we = 1'b0; p_we = 1'b0;
    d_a = '0; r_a = '0; p_a = '0;
    d_wd = val_r; p_wd = val_r;
    r_wd = val_r[VW-1] ? '0 : (val_r > VW'(MAX_PROFILE) ? PTW'(MAX_PROFILE) : val_r[PTW-1:0]);
    m_start = 1'b0; q_start = 1'b0; q_sqrt = 1'b0;
    q_num = '0; q_den = d_rd;
    i_nxt = i_r; j_nxt = j_r; i0_nxt = i0_r; i1_nxt = i1_r; k_nxt = k_r;
    ei_nxt = ei_r; ej_nxt = ej_r; begi_nxt = begi_r; ej0_nxt = ej0_r; ej1_nxt = ej1_r;
    acc_nxt = acc_r; opa_nxt = opa_r;
    begj = CW'(j_r) - (ej1_r - ej0_r);
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = S_DONE;
      end
      S_DONE: begin
        st_nxt = S_IDLE;
        res_set = 1'b1;
        unique case (op_r)
          OP_WR_DIAG: begin
            d_a = idx_r[RW-1:0];
            if (32'(idx_r) < MAX_ROWS) d_we = 1'b1; else res_s = ST_RANGE;
          end
          OP_WR_PTR: begin
            r_a = PRW'(idx_r);
            if (32'(idx_r) < MAX_ROWS + 1) r_we = 1'b1; else res_s = ST_RANGE;
          end
          OP_WR_PROF: begin
            p_a = PW'(idx_r);
            if (32'(idx_r) < MAX_PROFILE) p_we = 1'b1; else res_s = ST_RANGE;
          end
          OP_FACTOR: begin
            res_set = 1'b0;
            flag_nxt = 1'b0;
            i_nxt = '0;
            st_nxt = S_ROW;
          end
          OP_READ: begin
            res_set = 1'b0;
            d_a = idx_r[RW-1:0];
            p_a = PW'(idx_r[8:0]);
            st_nxt = S_RD_W;
          end
          default: ;
        endcase
      end
      S_RD_W: begin
        res_set = 1'b1;
        if (idx_r[9] ? (32'(idx_r[8:0]) < MAX_ROWS) : (32'(idx_r[8:0]) < MAX_PROFILE)) begin
          res_v = idx_r[9] ? d_rd : p_rd;
          res_s = flag_r ? ST_NOTDEF : ST_OK;
        end else res_s = ST_RANGE;
        st_nxt = S_IDLE;
      end
      S_ROW: begin
        if (i_r >= n_r) begin
          res_set = 1'b1; st_nxt = S_IDLE;
        end else begin
          r_a = PRW'(i_r); st_nxt = S_ROW_W1;
        end
      end
      S_ROW_W1: begin
        i0_nxt = CW'(r_rd); r_a = PRW'(i_r + 1'b1); st_nxt = S_ROW_W2;
      end
      S_ROW_W2: begin
        i1_nxt = CW'(r_rd); st_nxt = S_ROW_CHK;
      end
      S_ROW_CHK: begin
        if (i1_r < i0_r || (i1_r - i0_r) > CW'(i_r)) begin
          res_set = 1'b1; res_s = ST_RANGE; st_nxt = S_IDLE;
        end else begin
          begi_nxt = CW'(i_r) - (i1_r - i0_r);
          j_nxt = (RW+1)'(CW'(i_r) - (i1_r - i0_r));
          k_nxt = i0_r;
          st_nxt = S_COL;
        end
      end
      S_COL: begin
        if (k_r >= i1_r) begin
          acc_nxt = '0; ei_nxt = i0_r; st_nxt = S_SQ_RD;
        end else begin
          r_a = PRW'(j_r); st_nxt = S_COLP_W1;
        end
      end
      S_COLP_W1: begin
        ej0_nxt = CW'(r_rd); r_a = PRW'(j_r + 1'b1); st_nxt = S_COLP_W2;
      end
      S_COLP_W2: begin
        ej1_nxt = CW'(r_rd); st_nxt = S_COL_SET;
      end
      S_COL_SET: begin
        acc_nxt = '0;
        if (begj >= begi_r) begin
          ei_nxt = i0_r + (begj - begi_r); ej_nxt = ej0_r;
        end else begin
          ei_nxt = i0_r; ej_nxt = ej0_r + (begi_r - begj);
        end
        st_nxt = S_DOT_RD;
      end
      S_DOT_RD: begin
        if (ei_r >= k_r) st_nxt = S_DIV_RD;
        else begin
          p_a = ei_r[PW-1:0]; st_nxt = S_DOT_W;
        end
      end
      S_DOT_W: begin
        opa_nxt = p_rd; p_a = ej_r[PW-1:0]; st_nxt = S_DOT_MUL;
      end
      S_DOT_MUL: begin
        m_start = 1'b1; st_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        if (m_done) begin
          acc_nxt = sat_add(acc_r, m_p, 1'b0);
          ei_nxt = ei_r + 1'b1; ej_nxt = ej_r + 1'b1;
          st_nxt = S_DOT_RD;
        end
      end
      S_DIV_RD: begin
        p_a = k_r[PW-1:0]; d_a = j_r[RW-1:0]; st_nxt = S_DIV_W;
      end
      S_DIV_W: begin
        q_start = 1'b1; q_num = sat_add(p_rd, acc_r, 1'b1); q_den = d_rd;
        st_nxt = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (q_done) st_nxt = S_DIV_WR;
      end
      S_DIV_WR: begin
        p_a = k_r[PW-1:0]; p_wd = q_res; p_we = 1'b1;
        k_nxt = k_r + 1'b1; j_nxt = j_r + 1'b1; st_nxt = S_COL;
      end
      S_SQ_RD: begin
        if (ei_r >= i1_r) begin
          d_a = i_r[RW-1:0]; st_nxt = S_PIV_W;
        end else begin
          p_a = ei_r[PW-1:0]; st_nxt = S_SQ_W;
        end
      end
      S_SQ_W: begin
        opa_nxt = p_rd; p_a = ei_r[PW-1:0]; st_nxt = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        m_start = 1'b1; st_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        if (m_done) begin
          acc_nxt = sat_add(acc_r, m_p, 1'b0); ei_nxt = ei_r + 1'b1; st_nxt = S_SQ_RD;
        end
      end
      S_PIV_RD: st_nxt = S_PIV_W;
      S_PIV_W: begin
        if (sat_add(d_rd, acc_r, 1'b1) <= 0) begin
          flag_nxt = 1'b1; res_set = 1'b1; res_s = ST_NOTDEF; st_nxt = S_IDLE;
        end else begin
          q_start = 1'b1; q_sqrt = 1'b1; q_num = sat_add(d_rd, acc_r, 1'b1);
          st_nxt = S_SQRT_RUN;
        end
      end
      S_SQRT_RUN: begin
        if (q_done) st_nxt = S_SQRT_WR;
      end
      S_SQRT_WR: begin
        d_a = i_r[RW-1:0]; d_wd = q_res; d_we = 1'b1;
        i_nxt = i_r + 1'b1; st_nxt = S_ROW;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      flag_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      flag_r <= flag_nxt;
      if (res_set) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_tdata[2:0];
      idx_r <= in_tdata[12:3];
      val_r <= $signed(in_tdata[60:13]);
      n_r <= (32'(msize_r) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(msize_r);
    end
    if (res_set) begin
      orv_r <= res_v;
      ost_r <= res_s;
    end
    i_r <= i_nxt; j_r <= j_nxt; i0_r <= i0_nxt; i1_r <= i1_nxt; k_r <= k_nxt;
    ei_r <= ei_nxt; ej_r <= ej_nxt; begi_r <= begi_nxt; ej0_r <= ej0_nxt;
    ej1_r <= ej1_nxt; acc_r <= acc_nxt; opa_r <= opa_nxt;
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == S_IDLE) && !ov_r) else $error("ready while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(m_start && q_start)) else $error("two units started");
  a_flag_status: assert property (@(posedge clk) disable iff (!rst_n)
    res_set && res_s == ST_NOTDEF && st_r != S_RD_W |-> flag_nxt)
    else $error("status without flag");
`endif
endmodule
`default_nettype wire

@@ rtl/core/slc_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module slc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/slc_mul.sv @@
// Fixed-point multiplier: 48x48 magnitude product over four 24x24 partial products,
// rounded to nearest and saturated. Uses slc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slc_mul
  import slc_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [VW-1:0] a,
  input  wire logic signed [VW-1:0] b,
  output logic                      done,
  output logic signed [VW-1:0]      p
);
  localparam int HW = VW / 2;
  logic [VW-1:0] am_r, bm_r;
  logic neg_r;
  logic [2:0] cnt_r;
  logic busy_r;
  logic [2*VW-1:0] acc_r;
  logic [HW-1:0] pa, pb;
  logic [2*HW-1:0] pp;
  logic [2*VW-1:0] ppx, rnd;
  logic [2*VW-1:0] shifted;

  always_comb begin
    pa = cnt_r[0] ? am_r[VW-1:HW] : am_r[HW-1:0];
    pb = cnt_r[1] ? bm_r[VW-1:HW] : bm_r[HW-1:0];
    pp = pa * pb;
    ppx = {{(2*VW-2*HW){1'b0}}, pp} << (HW * (32'(cnt_r[0]) + 32'(cnt_r[1])));
    rnd = acc_r + ({{(2*VW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
    shifted = rnd >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        acc_r <= '0;
        am_r <= a[VW-1] ? VW'(-a) : a;
        bm_r <= b[VW-1] ? VW'(-b) : b;
        neg_r <= a[VW-1] ^ b[VW-1];
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done <= 1'b1;
          if (shifted > {{VW{1'b0}}, VMAX}) p <= neg_r ? -VMAX : VMAX;
          else p <= neg_r ? -$signed(shifted[VW-1:0]) : $signed(shifted[VW-1:0]);
        end else begin
          acc_r <= acc_r + ppx;
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/slc_divsqrt.sv @@
// Shared bit-serial divider and square root, one quotient or root bit per cycle.
// Uses slc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slc_divsqrt
  import slc_pkg::*;
#(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 is_sqrt,
  input  wire logic signed [VW-1:0] num,
  input  wire logic signed [VW-1:0] den,
  output logic                      done,
  output logic signed [VW-1:0]      res
);
  localparam int NW = VW + FRAC_BITS;
  localparam int DSTEPS = NW;
  localparam int SSTEPS = (NW + 1) / 2;
  logic busy_r, sq_r, neg_r;
  logic [$clog2(NW+1)-1:0] cnt_r;
  logic [2*((NW+1)/2)-1:0] n_r;
  logic [VW:0] d_r;
  logic [NW+1:0] rem_r;
  logic [NW-1:0] q_r;
  logic [NW+1:0] rem_d, trial_s, rem_s;
  logic [NW-1:0] qm;

  always_comb begin
    rem_d = {rem_r[NW:0], n_r[2*((NW+1)/2)-1]};
    rem_s = {rem_r[NW-1:0], n_r[2*((NW+1)/2)-1 -: 2]};
    trial_s = {q_r[NW-1:0], 2'b01};
    qm = q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sq_r <= is_sqrt;
        neg_r <= num[VW-1] ^ den[VW-1];
        rem_r <= '0;
        q_r <= '0;
        cnt_r <= '0;
        d_r <= {1'b0, den[VW-1] ? VW'(-den) : den};
        n_r <= ($bits(n_r))'({num[VW-1] ? VW'(-num) : num, {FRAC_BITS{1'b0}}})
               << (is_sqrt ? 0 : ($bits(n_r) - NW));
        if (!is_sqrt && (num == '0)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
          res <= '0;
        end else if (!is_sqrt && (den == '0)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
          res <= num[VW-1] ? -VMAX : VMAX;
        end
      end else if (busy_r) begin
        if (!sq_r) begin
          if (32'(cnt_r) == DSTEPS) begin
            busy_r <= 1'b0;
            done <= 1'b1;
            if (qm > NW'(VMAX)) res <= neg_r ? -VMAX : VMAX;
            else res <= neg_r ? -$signed(qm[VW-1:0]) : $signed(qm[VW-1:0]);
          end else begin
            n_r <= n_r << 1;
            cnt_r <= cnt_r + 1'b1;
            if (rem_d >= {{(NW+1-VW){1'b0}}, d_r}) begin
              rem_r <= rem_d - {{(NW+1-VW){1'b0}}, d_r};
              q_r <= {q_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rem_d;
              q_r <= {q_r[NW-2:0], 1'b0};
            end
          end
        end else begin
          if (32'(cnt_r) == SSTEPS) begin
            busy_r <= 1'b0;
            done <= 1'b1;
            if (qm > NW'(VMAX)) res <= VMAX;
            else res <= $signed(qm[VW-1:0]);
          end else begin
            n_r <= n_r << 2;
            cnt_r <= cnt_r + 1'b1;
            if (rem_s >= trial_s) begin
              rem_r <= rem_s - trial_s;
              q_r <= {q_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rem_s;
              q_r <= {q_r[NW-2:0], 1'b0};
            end
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for skyline_cholesky_factor: directed table, then random build/factor/read runs.
// Every beat is checked against the directed table's values or an in-bench fixed-point predictor.
// Depends on slc_pkg and the skyline_cholesky_factor RTL.
`timescale 1ns / 1ps
module tb_top;
  import slc_pkg::*;

  localparam longint VTOP = 64'sh7FFF_FFFF_FFFF;
  localparam longint ONE = 64'sd1 << 24;
  localparam int WATCH_LIMIT = 200000;

  typedef struct {
    logic [2:0] op;
    logic [9:0] idx;
    longint val;
    bit fixed;
    longint f_rv;
    logic [1:0] f_st;
  } beat_t;

  typedef struct {
    logic [47:0] rv;
    logic [1:0] st;
  } result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [63:0] in_tdata;   // opcode[2:0], index[12:3], value[60:13]
  logic [55:0] out_tdata;  // read_value[47:0], status[49:48]
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  skyline_cholesky_factor dut (.*);

  longint diag_m[64];
  longint prof_m[1024];
  int ptr_m[65];
  bit flag_m;
  int size_m;
  bit diag_wr[64];
  bit prof_wr[1024];

  beat_t stim_q[$];
  result_t result_q[$];
  beat_t cur;
  bit took, idle_en;
  int errors, sent, got, factors, idle_cnt;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat48(longint v);
    if (v > VTOP) return VTOP;
    if (v < -VTOP) return -VTOP;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    longint ma, mb, mag;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = 128'(ma) * 128'(mb);
    p = (p + (128'd1 << 23)) >> 24;
    mag = p > 128'(VTOP) ? VTOP : longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -mag : mag;
  endfunction

  function automatic longint fx_div(longint num, longint den);
    logic [127:0] q;
    longint mn, md, mag;
    if (num == 0) return 0;
    if (den == 0) return num < 0 ? -VTOP : VTOP;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (128'(mn) << 24) / 128'(md);
    mag = q > 128'(VTOP) ? VTOP : longint'(q[63:0]);
    return ((num < 0) != (den < 0)) ? -mag : mag;
  endfunction

  function automatic longint fx_sqrt(longint v);
    logic [127:0] n, root, rem, trial;
    n = 128'(v) << 24;
    root = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 128'(n[2*i+1 -: 2]);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return sat48(longint'(root[63:0]));
  endfunction

  function automatic logic [1:0] factor_model();
    int n, i0, i1, beg_i, beg_j, j, ei, ej;
    longint acc;
    n = size_m > 64 ? 64 : size_m;
    flag_m = 0;
    for (int i = 0; i < n; i++) begin
      i0 = ptr_m[i];
      i1 = ptr_m[i+1];
      if (i1 < i0 || i1 - i0 > i) return ST_RANGE;
      beg_i = i - (i1 - i0);
      j = beg_i;
      for (int k = i0; k < i1; k++) begin
        ej = ptr_m[j];
        beg_j = j - (ptr_m[j+1] - ej);
        ei = i0;
        if (beg_j >= beg_i) ei += beg_j - beg_i;
        else ej += beg_i - beg_j;
        acc = 0;
        while (ei < k) begin
          acc = sat48(acc + fx_mul(prof_m[ei], prof_m[ej]));
          ei++;
          ej++;
        end
        prof_m[k] = fx_div(sat48(prof_m[k] - acc), diag_m[j]);
        j++;
      end
      acc = 0;
      for (int k = i0; k < i1; k++) acc = sat48(acc + fx_mul(prof_m[k], prof_m[k]));
      acc = sat48(diag_m[i] - acc);
      if (acc <= 0) begin
        flag_m = 1;
        return ST_NOTDEF;
      end
      diag_m[i] = fx_sqrt(acc);
    end
    return ST_OK;
  endfunction

  function automatic result_t predict_beat(beat_t b);
    result_t r;
    int a;
    r.rv = 0;
    r.st = ST_OK;
    case (b.op)
      OP_WR_DIAG: begin
        if (b.idx < 64) diag_m[b.idx] = b.val;
        else r.st = ST_RANGE;
      end
      OP_WR_PTR: begin
        if (b.idx < 65) ptr_m[b.idx] = b.val < 0 ? 0 : (b.val > 1024 ? 1024 : int'(b.val));
        else r.st = ST_RANGE;
      end
      OP_WR_PROF: prof_m[b.idx] = b.val;
      OP_FACTOR: r.st = factor_model();
      OP_READ: begin
        a = b.idx[8:0];
        if (b.idx[9] && a >= 64) begin
          r.st = ST_RANGE;
        end else begin
          r.rv = b.idx[9] ? diag_m[a][47:0] : prof_m[a][47:0];
          r.st = flag_m ? ST_NOTDEF : ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [47:0] seen, logic [47:0] want);
    $display("mismatch at beat %0d: %s got %h want %h", got, what, seen, want);
    errors++;
  endtask

  task automatic push(logic [2:0] op, logic [9:0] idx, longint val);
    beat_t b;
    b = '{op, idx, val, 1'b0, 0, ST_OK};
    if (op == OP_WR_DIAG && idx < 64) diag_wr[idx] = 1;
    if (op == OP_WR_PROF) prof_wr[idx] = 1;
    stim_q.push_back(b);
    sent++;
  endtask

  task automatic push_fixed(logic [2:0] op, logic [9:0] idx, longint val, longint rv,
                            logic [1:0] st);
    beat_t b;
    b = '{op, idx, val, 1'b1, rv, st};
    stim_q.push_back(b);
    sent++;
  endtask

  task automatic drain();
    while (stim_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(int sz);
    drain();
    @(negedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= {REG_MATRIX_SIZE, 2'b00};
    cfg_pwdata <= 32'(sz);
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    size_m = sz & 32'h7F;
  endtask

  function automatic longint rand48();
    logic [47:0] v;
    v = {16'($urandom), $urandom};
    return longint'($signed(v));
  endfunction

  function automatic longint small_val();
    return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
  endfunction

  task automatic noise(int count);
    logic [9:0] idx;
    int pick;
    for (int c = 0; c < count; c++) begin
      idx = 10'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        push(OP_WR_DIAG, idx, rand48());
      end else if (pick < 4) begin
        push(OP_WR_PTR, idx, rand48());
      end else if (pick < 5) begin
        push(OP_WR_PROF, idx, rand48());
      end else if (pick < 8) begin
        if (idx[9] && idx[8:0] < 64 && !diag_wr[idx[8:0]]) idx[8:6] = 3'($urandom_range(1, 7));
        if (!idx[9] && !prof_wr[idx[8:0]]) idx = {1'b1, 3'($urandom_range(1, 7)), idx[5:0]};
        push(OP_READ, idx, rand48());
      end else begin
        push(OP_READ + 3'($urandom_range(1, 3)), idx, rand48());
      end
    end
  endtask

  task automatic build_run(int sz, int band);
    int eff, len, top, bad;
    int ptr[65];
    eff = sz > 64 ? 64 : sz;
    cfg_write(sz);
    bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, eff) : -1;
    ptr[0] = 0;
    top = 0;
    for (int i = 0; i < eff; i++) begin
      len = $urandom_range(0, i < band ? i : band);
      ptr[i+1] = ptr[i] + len;
      if (i == bad) ptr[i+1] = ($urandom_range(0, 1) && ptr[i] > 0) ? ptr[i] - 1 : ptr[i] + i + 1;
      if (ptr[i+1] > top) top = ptr[i+1];
    end
    for (int i = 0; i <= eff; i++) push(OP_WR_PTR, 10'(i), ptr[i]);
    for (int k = 0; k < top; k++)
      push(OP_WR_PROF, 10'(k), $urandom_range(0, 15) == 0 ? rand48() : small_val());
    for (int i = 0; i < eff; i++)
      push(OP_WR_DIAG, 10'(i), $urandom_range(0, 11) == 0 ? -small_val() :
           longint'($urandom_range(1, 4) + band) * ONE + small_val() + ONE);
    push(OP_FACTOR, 10'($urandom), rand48());
    factors++;
    for (int r = $urandom_range(2, 6); r > 0; r--) begin
      if (eff > 0 && $urandom_range(0, 1))
        push(OP_READ, {1'b1, 9'($urandom_range(0, eff - 1))}, rand48());
      else if (top > 0)
        push(OP_READ, {1'b0, 9'($urandom_range(0, top > 512 ? 511 : top - 1))}, rand48());
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || took) begin
        took = 0;
        if (stim_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < 18)) begin
          cur = stim_q.pop_front();
          in_tdata <= {3'b000, cur.val[47:0], cur.idx, cur.op};
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
        end
      end
      out_tready <= !(idle_en && $urandom_range(0, 99) < 18);
    end
  end

  always @(posedge clk) begin
    result_t want, pred;
    if (rst_n) begin
      idle_cnt++;
      if (out_tvalid && out_tready) begin
        idle_cnt = 0;
        if (result_q.size() == 0) begin
          report("unexpected beat", out_tdata[47:0], 48'd0);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[47:0] !== want.rv) report("read_value", out_tdata[47:0], want.rv);
          if (out_tdata[49:48] !== want.st) report("status", 48'(out_tdata[49:48]), 48'(want.st));
        end
        got++;
      end
      if (in_tvalid && in_tready) begin
        idle_cnt = 0;
        took = 1;
        pred = predict_beat(cur);
        if (cur.fixed) begin
          pred.rv = cur.f_rv[47:0];
          pred.st = cur.f_st;
        end
        result_q.push_back(pred);
      end
      if (idle_cnt >= WATCH_LIMIT) begin
        $display("no progress for %0d cycles", WATCH_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = 0;
    cfg_pwdata = 0;
    size_m = 1;
    flag_m = 0;
    idle_en = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    push_fixed(OP_WR_DIAG, 10'd0, ONE, 0, ST_OK);
    push_fixed(OP_WR_DIAG, 10'd63, VTOP, 0, ST_OK);
    push_fixed(OP_WR_DIAG, 10'd64, ONE, 0, ST_RANGE);
    push_fixed(OP_WR_DIAG, 10'd1023, -(VTOP + 1), 0, ST_RANGE);
    push_fixed(OP_WR_PTR, 10'd0, -5, 0, ST_OK);
    push_fixed(OP_WR_PTR, 10'd1, VTOP, 0, ST_OK);
    push_fixed(OP_FACTOR, 10'd0, 0, 0, ST_RANGE);
    push_fixed(OP_WR_PTR, 10'd65, 0, 0, ST_RANGE);
    push_fixed(OP_WR_PTR, 10'd1, 0, 0, ST_OK);
    push_fixed(OP_WR_PROF, 10'd511, -(VTOP + 1), 0, ST_OK);
    push_fixed(OP_WR_PROF, 10'd0, VTOP, 0, ST_OK);
    push_fixed(OP_WR_PROF, 10'd1023, ONE, 0, ST_OK);
    push_fixed(OP_READ, 10'd511, 0, -(VTOP + 1), ST_OK);
    push_fixed(OP_READ, 10'd0, 0, VTOP, ST_OK);
    push_fixed(OP_FACTOR, 10'd0, 0, 0, ST_OK);
    push_fixed(OP_READ, 10'h200, 0, ONE, ST_OK);
    push_fixed(OP_WR_DIAG, 10'd0, -ONE, 0, ST_OK);
    push_fixed(OP_FACTOR, 10'd0, 0, 0, ST_NOTDEF);
    push_fixed(OP_READ, 10'h200, 0, -ONE, ST_NOTDEF);
    push_fixed(OP_READ, 10'h23F, 0, VTOP, ST_NOTDEF);
    push_fixed(OP_READ, 10'h240, 0, 0, ST_RANGE);
    push_fixed(OP_READ, 10'h3FF, 0, 0, ST_RANGE);
    for (int j = 1; j <= 3; j++) push_fixed(OP_READ + 3'(j), 10'h3FF, -1, 0, ST_OK);
    push_fixed(OP_WR_DIAG, 10'd0, 4 * ONE, 0, ST_OK);
    push_fixed(OP_FACTOR, 10'd0, 0, 0, ST_OK);
    push_fixed(OP_READ, 10'h200, 0, 2 * ONE, ST_OK);
    foreach (stim_q[q]) begin
      if (stim_q[q].op == OP_WR_DIAG && stim_q[q].idx < 64) diag_wr[stim_q[q].idx] = 1;
      if (stim_q[q].op == OP_WR_PROF) prof_wr[stim_q[q].idx] = 1;
    end
    cfg_write(0);
    push_fixed(OP_FACTOR, 10'd0, 0, 0, ST_OK);

    build_run(64, 3);
    cfg_write(127);
    push(OP_FACTOR, 10'd0, 0);
    push(OP_READ, 10'h23F, 0);
    for (int it = 0; sent < 900; it++) begin
      idle_en = !(sent > 350 && sent < 550);
      if ($urandom_range(0, 3) == 0) noise($urandom_range(5, 15));
      else build_run($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8), $urandom_range(1, 4));
    end
    build_run(1, 1);

    drain();
    repeat (20) @(posedge clk);
    $display("%0d beats sent, %0d results checked, %0d factorize runs", sent, got, factors);
    $display("sizes 0, 1 to 8, 64 and 127; saturation, range and indefinite pivots covered");
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
